// File: sv/eth_arp_ipv4_l4_header_parser_top_assert.svh
// Assertion macros for the header parser modules; hep_fifo includes them.
`ifndef ETH_ARP_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define ETH_ARP_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define HEP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("header parser assertion failed");
// Clocked check that also holds during reset.
`define HEP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("header parser assertion failed");
`else
`define HEP_ASSERT(lbl, clk, rst_n, prop)
`define HEP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/hep_pkg.sv
// Types and constants shared by the header parser modules.
`timescale 1ns / 1ps
`default_nettype none

package hep_pkg;

    // Frames longer than this are dropped; bytes beyond it are ignored.
    localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

    localparam int ETH_LEN = 14;
    localparam int ARP_LEN = 28;
    localparam int IP_MIN  = 20;
    localparam int TCP_MIN = 20;
    localparam int UDP_LEN = 8;

    localparam logic [15:0] TYPE_ARP   = 16'h0806;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_NUM_TCP = 8'd6;
    localparam logic [7:0]  IP_NUM_UDP = 8'd17;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [QUEUE_AW-1:0] t_qaddr;
    typedef logic [QUEUE_CW-1:0] t_qcount;

    // Everything captured from one frame, as it stands after its last byte.
    typedef struct packed {
        logic [15:0] len;
        logic        too_long;
        logic [15:0] ether_type;
        logic [47:0] src_mac;
        logic [15:0] arp_op;
        logic [47:0] arp_sha;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [7:0]  proto;
        logic [5:0]  ihl;
        logic [31:0] ports;
        logic [5:0]  tcp_hlen;
        logic [7:0]  l4_flags;
    } t_frame_info;

    // Output record; the first field sits in the highest bits.
    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [15:0] payload_start;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [7:0]  ip_protocol;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [47:0] arp_sender_mac;
        logic [15:0] arp_operation;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
    } t_record;

    localparam int REC_W = $bits(t_record);

endpackage

`default_nettype wire

// File: sv/hep_front.sv
// Front part: takes frame bytes and captures header fields at their offsets.
`timescale 1ns / 1ps
`default_nettype none

module hep_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [7:0]           i_s_tdata,
    input  wire logic                 i_s_tlast,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output hep_pkg::t_frame_info      o_q_data
);

    hep_pkg::t_frame_info r_st;
    hep_pkg::t_frame_info n_st;

    logic        w_acc;
    logic [15:0] w_pos;
    logic [5:0]  w_hlen;
    logic [6:0]  w_base;
    logic [16:0] w_diff;
    logic [15:0] w_rel;
    logic        w_in_l4;
    logic        w_arp;

    assign o_s_tready = !i_q_full;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_pos      = r_st.len;
    assign w_arp      = (r_st.ether_type == hep_pkg::TYPE_ARP);

    // The header length written by byte 14 already counts for byte 14 itself.
    assign w_hlen  = (w_pos == 16'(hep_pkg::ETH_LEN)) ? {i_s_tdata[3:0], 2'b00} : r_st.ihl;
    assign w_base  = 7'(hep_pkg::ETH_LEN) + {1'b0, w_hlen};
    assign w_diff  = {1'b0, w_pos} - {10'b0, w_base};
    assign w_rel   = w_diff[15:0];
    assign w_in_l4 = !w_diff[16];

    always_comb begin
        n_st = r_st;
        if (w_acc) begin
            if (w_pos >= hep_pkg::MAX_FRAME_BYTES) begin
                n_st.too_long = 1'b1;
            end else begin
                n_st.len = w_pos + 16'd1;
                if (w_pos >= 16'd6 && w_pos <= 16'd11) begin
                    n_st.src_mac = {r_st.src_mac[39:0], i_s_tdata};
                end
                if (w_pos == 16'd12 || w_pos == 16'd13) begin
                    n_st.ether_type = {r_st.ether_type[7:0], i_s_tdata};
                end
                if (w_pos == 16'd20 || w_pos == 16'd21) begin
                    n_st.arp_op = {r_st.arp_op[7:0], i_s_tdata};
                end
                if (w_pos >= 16'd22 && w_pos <= 16'd27) begin
                    n_st.arp_sha = {r_st.arp_sha[39:0], i_s_tdata};
                end
                if (w_pos == 16'd23) begin
                    n_st.proto = i_s_tdata;
                end
                if (w_pos == 16'(hep_pkg::ETH_LEN)) begin
                    n_st.ihl = w_hlen;
                end
                // ARP protocol addresses and IPv4 addresses share the address registers.
                if (w_arp) begin
                    if (w_pos >= 16'd28 && w_pos <= 16'd31) begin
                        n_st.addr_a = {r_st.addr_a[23:0], i_s_tdata};
                    end
                    if (w_pos >= 16'd38 && w_pos <= 16'd41) begin
                        n_st.addr_b = {r_st.addr_b[23:0], i_s_tdata};
                    end
                end else begin
                    if (w_pos >= 16'd26 && w_pos <= 16'd29) begin
                        n_st.addr_a = {r_st.addr_a[23:0], i_s_tdata};
                    end
                    if (w_pos >= 16'd30 && w_pos <= 16'd33) begin
                        n_st.addr_b = {r_st.addr_b[23:0], i_s_tdata};
                    end
                end
                if (w_in_l4) begin
                    if (w_rel <= 16'd3) begin
                        n_st.ports = {r_st.ports[23:0], i_s_tdata};
                    end
                    if (w_rel == 16'd12) begin
                        n_st.tcp_hlen = {i_s_tdata[7:4], 2'b00};
                    end
                    if (w_rel == 16'd13) begin
                        n_st.l4_flags = i_s_tdata;
                    end
                end
            end
        end
    end

    assign o_q_push = w_acc && i_s_tlast;
    assign o_q_data = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (o_q_push) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

// File: sv/hep_fifo.sv
// Short queue of captured frame summaries between front and back.
`timescale 1ns / 1ps
`default_nettype none

`include "eth_arp_ipv4_l4_header_parser_top_assert.svh"

module hep_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire hep_pkg::t_frame_info i_push_data,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_pop,
    output hep_pkg::t_frame_info      o_pop_data
);

    hep_pkg::t_frame_info r_mem [hep_pkg::QUEUE_DEPTH];
    hep_pkg::t_qaddr      r_wr_ptr;
    hep_pkg::t_qaddr      r_rd_ptr;
    hep_pkg::t_qcount     r_count;

    assign o_full     = (r_count == hep_pkg::t_qcount'(hep_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `HEP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= hep_pkg::t_qcount'(hep_pkg::QUEUE_DEPTH))
    `HEP_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full)
    `HEP_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> o_valid)
    `HEP_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == hep_pkg::t_qcount'($past(r_count) + 1'b1)))

endmodule

`default_nettype wire

// File: sv/hep_back.sv
// Back part: checks each frame's length and forms the output record.
`timescale 1ns / 1ps
`default_nettype none

module hep_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire hep_pkg::t_frame_info i_q_data,
    output logic                      o_q_pop,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output hep_pkg::t_record          o_m_tdata
);

    logic             r_out_valid;
    hep_pkg::t_record r_out_data;

    hep_pkg::t_record w_rec;
    logic             w_ok;
    logic [15:0]      w_len;
    logic [7:0]       w_base;
    logic [7:0]       w_tcp_start;
    logic [7:0]       w_udp_start;

    assign w_len       = i_q_data.len;
    assign w_base      = 8'(hep_pkg::ETH_LEN) + {2'b00, i_q_data.ihl};
    assign w_tcp_start = w_base + {2'b00, i_q_data.tcp_hlen};
    assign w_udp_start = w_base + 8'(hep_pkg::UDP_LEN);

    // Every header minimum is compared against the total frame length.
    always_comb begin
        w_rec = '0;
        w_ok  = 1'b0;
        w_rec.ether_type = i_q_data.ether_type;
        w_rec.source_mac = i_q_data.src_mac;
        if (!i_q_data.too_long && w_len >= 16'(hep_pkg::ETH_LEN)) begin
            if (i_q_data.ether_type == hep_pkg::TYPE_ARP) begin
                w_ok                 = (w_len >= 16'(hep_pkg::ETH_LEN + hep_pkg::ARP_LEN));
                w_rec.arp_operation  = i_q_data.arp_op;
                w_rec.arp_sender_mac = i_q_data.arp_sha;
                w_rec.source_addr    = i_q_data.addr_a;
                w_rec.dest_addr      = i_q_data.addr_b;
            end else if (i_q_data.ether_type == hep_pkg::TYPE_IPV4) begin
                w_rec.source_addr = i_q_data.addr_a;
                w_rec.dest_addr   = i_q_data.addr_b;
                w_rec.ip_protocol = i_q_data.proto;
                w_ok = (w_len >= 16'(hep_pkg::ETH_LEN + hep_pkg::IP_MIN))
                    && (w_len >= {8'b0, w_base});
                if (i_q_data.proto == hep_pkg::IP_NUM_TCP) begin
                    w_ok = w_ok && (w_len >= {8'b0, w_base} + 16'(hep_pkg::TCP_MIN));
                    w_rec.source_port   = i_q_data.ports[31:16];
                    w_rec.dest_port     = i_q_data.ports[15:0];
                    w_rec.tcp_flag_bits = i_q_data.l4_flags;
                    // Payload only when the data offset stays inside the frame.
                    if (w_len >= {8'b0, w_tcp_start}) begin
                        w_rec.payload_start = {8'b0, w_tcp_start};
                        w_rec.payload_bytes = w_len - {8'b0, w_tcp_start};
                    end
                end else if (i_q_data.proto == hep_pkg::IP_NUM_UDP) begin
                    w_ok = w_ok && (w_len >= {8'b0, w_udp_start});
                    w_rec.source_port   = i_q_data.ports[31:16];
                    w_rec.dest_port     = i_q_data.ports[15:0];
                    w_rec.payload_start = {8'b0, w_udp_start};
                    w_rec.payload_bytes = w_len - {8'b0, w_udp_start};
                end
            end
        end
    end

    assign o_q_pop    = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= w_ok;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && w_ok) begin
            r_out_data <= w_rec;
        end
    end

endmodule

`default_nettype wire

// File: sv/eth_arp_ipv4_l4_header_parser_top.sv
// Top level of the Ethernet / ARP / IPv4 / TCP-UDP header parser.
//
// Input stream: one frame byte per word on i_s_tdata, i_s_tlast on the last byte.
// Output stream: one record word per ARP or IPv4 frame that is long enough for its
// headers; short, oversize and other frames give no word.
// Throughput: one byte per cycle while the queue is not full. Bytes are captured by a
// front stage as they pass; on the last byte the frame summary enters a two-entry
// queue, and a back stage checks the lengths and loads the output register, one frame
// per cycle while that register is free or its word is taken. A frame's summary goes
// from the queue register into the output register, which raises o_m_tvalid.
// When the receiver stalls, the output register holds its word, the queue fills,
// and o_s_tready drops only once two more frame summaries wait behind it.
// Reset (i_rst_n low, synchronous) clears the byte position, all captured fields,
// the queue and the output valid; the block is ready again the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module eth_arp_ipv4_l4_header_parser_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,   // frame_byte
    input  wire logic                        i_s_tlast,   // frame_end
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // ether_type, source_mac, arp_operation, arp_sender_mac, source_addr, dest_addr,
    // ip_protocol, source_port, dest_port, tcp_flag_bits, payload_start, payload_bytes
    output logic [hep_pkg::REC_W-1:0]        o_m_tdata
);

    logic                 w_q_full;
    logic                 w_q_push;
    hep_pkg::t_frame_info w_q_wdata;
    logic                 w_q_valid;
    logic                 w_q_pop;
    hep_pkg::t_frame_info w_q_rdata;
    hep_pkg::t_record     w_rec;

    hep_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    hep_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_data (w_q_wdata),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .i_pop       (w_q_pop),
        .o_pop_data  (w_q_rdata)
    );

    hep_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (w_rec)
    );

    assign o_m_tdata = w_rec;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Ethernet / ARP / IPv4 / TCP-UDP header parser.
`timescale 1ns / 1ps

module tb_top;
    import hep_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 1150;
    localparam int RANDOM_RECORDS = 40;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 10000000;
    localparam int DIRECTED_ROWS  = 24;

    localparam bit REC_PREDICTED = 1'b0;
    localparam bit REC_NONE      = 1'b1;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

    // One frame to send: EtherType, length in bytes, IPv4 and TCP header
    // words, byte fill, and whether "no record" is the known outcome.
    typedef struct packed {
        logic [15:0] etype;
        logic [16:0] len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [3:0]  doff;
        fill_kind_t  fill;
        logic        no_record;
    } frame_cfg_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [7:0]              i_s_tdata = 8'h00;   // frame_byte
    logic                    i_s_tlast = 1'b0;    // frame_end
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // ether_type, source_mac, arp_operation, arp_sender_mac, source_addr, dest_addr,
    // ip_protocol, source_port, dest_port, tcp_flag_bits, payload_start, payload_bytes
    logic [REC_W-1:0]        o_m_tdata;

    eth_arp_ipv4_l4_header_parser_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    int cycle_count;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Shadow of the parser state.
    logic [15:0] sh_pos;
    logic        sh_over;
    logic [15:0] sh_type;
    logic [47:0] sh_src_mac;
    logic [15:0] sh_arp_op;
    logic [47:0] sh_arp_sha;
    logic [31:0] sh_addr_a;
    logic [31:0] sh_addr_b;
    logic [7:0]  sh_proto;
    logic [5:0]  sh_hlen;
    logic [31:0] sh_ports;
    logic [5:0]  sh_thl;
    logic [7:0]  sh_flags;

    t_record     pending_records[$];
    bit          frame_outcome_known[$];
    frame_cfg_t  directed_frames [DIRECTED_ROWS];

    int mismatch_count;
    int records_predicted;
    int records_checked;
    int frames_sent;
    int frames_dropped;
    int bytes_sent;
    bit hold_request;
    bit hold_active;
    bit hold_done;

    task automatic clear_shadow();
        sh_pos = '0; sh_over = 1'b0; sh_type = '0; sh_src_mac = '0;
        sh_arp_op = '0; sh_arp_sha = '0; sh_addr_a = '0; sh_addr_b = '0;
        sh_proto = '0; sh_hlen = '0; sh_ports = '0; sh_thl = '0; sh_flags = '0;
    endtask

    // Captures one byte into the shadow state; on the last byte it decides
    // whether the frame yields a record and what that record holds.
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output bit rec_valid, output t_record rec);
        int p;
        int r;
        int len;
        int rem;
        int rem2;
        rec_valid = 1'b0;
        rec = '0;
        if (sh_pos >= MAX_FRAME_BYTES) begin
            sh_over = 1'b1;
        end else begin
            p = int'(sh_pos);
            if (p >= 6 && p <= 11) sh_src_mac = {sh_src_mac[39:0], b};
            if (p == 12 || p == 13) sh_type = {sh_type[7:0], b};
            if (p == 20 || p == 21) sh_arp_op = {sh_arp_op[7:0], b};
            if (p >= 22 && p <= 27) sh_arp_sha = {sh_arp_sha[39:0], b};
            if (p == 23) sh_proto = b;
            if (p == 14) sh_hlen = {b[3:0], 2'b00};
            if (sh_type == TYPE_ARP) begin
                if (p >= 28 && p <= 31) sh_addr_a = {sh_addr_a[23:0], b};
                if (p >= 38 && p <= 41) sh_addr_b = {sh_addr_b[23:0], b};
            end else begin
                if (p >= 26 && p <= 29) sh_addr_a = {sh_addr_a[23:0], b};
                if (p >= 30 && p <= 33) sh_addr_b = {sh_addr_b[23:0], b};
            end
            // The L4 offset uses the header length as it stands after this byte.
            if (p >= ETH_LEN + int'(sh_hlen)) begin
                r = p - ETH_LEN - int'(sh_hlen);
                if (r <= 3) sh_ports = {sh_ports[23:0], b};
                if (r == 12) sh_thl = {b[7:4], 2'b00};
                if (r == 13) sh_flags = b;
            end
            sh_pos = sh_pos + 16'd1;
        end
        if (last) begin
            len = int'(sh_pos);
            if (!sh_over && len >= ETH_LEN) begin
                rem = len - ETH_LEN;
                rec.ether_type = sh_type;
                rec.source_mac = sh_src_mac;
                if (sh_type == TYPE_ARP) begin
                    if (rem >= ARP_LEN) begin
                        rec.arp_operation  = sh_arp_op;
                        rec.arp_sender_mac = sh_arp_sha;
                        rec.source_addr    = sh_addr_a;
                        rec.dest_addr      = sh_addr_b;
                        rec_valid = 1'b1;
                    end
                end else if (sh_type == TYPE_IPV4) begin
                    if (rem >= IP_MIN && rem >= int'(sh_hlen)) begin
                        rem2 = rem - int'(sh_hlen);
                        rec.source_addr = sh_addr_a;
                        rec.dest_addr   = sh_addr_b;
                        rec.ip_protocol = sh_proto;
                        rec_valid = 1'b1;
                        if (sh_proto == IP_NUM_TCP) begin
                            if (rem2 < TCP_MIN) begin
                                rec_valid = 1'b0;
                            end else begin
                                rec.source_port   = sh_ports[31:16];
                                rec.dest_port     = sh_ports[15:0];
                                rec.tcp_flag_bits = sh_flags;
                                // Payload fields stay zero when the data offset
                                // runs past the end of the frame.
                                if (rem2 >= int'(sh_thl)) begin
                                    rec.payload_start = 16'(ETH_LEN + sh_hlen + sh_thl);
                                    rec.payload_bytes = 16'(rem2 - int'(sh_thl));
                                end
                            end
                        end else if (sh_proto == IP_NUM_UDP) begin
                            if (rem2 < UDP_LEN) begin
                                rec_valid = 1'b0;
                            end else begin
                                rec.source_port   = sh_ports[31:16];
                                rec.dest_port     = sh_ports[15:0];
                                rec.payload_start = 16'(ETH_LEN + sh_hlen + UDP_LEN);
                                rec.payload_bytes = 16'(rem2 - UDP_LEN);
                            end
                        end
                    end
                end
            end
            clear_shadow();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    initial clear_shadow();

    // Input side: every accepted word goes through the shadow parser.
    always @(posedge i_clk) begin : input_monitor
        bit      rec_valid;
        t_record rec;
        bit      known_none;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            parse_byte(i_s_tdata, i_s_tlast, rec_valid, rec);
            if (i_s_tlast) begin
                known_none = frame_outcome_known.pop_front();
                if (known_none) rec_valid = 1'b0;
                if (rec_valid) begin
                    pending_records.push_back(rec);
                    records_predicted++;
                end else begin
                    frames_dropped++;
                end
            end
        end
    end

    // Output side: every accepted record is compared with the oldest prediction.
    always @(posedge i_clk) begin : output_monitor
        t_record want;
        t_record got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record %0h", $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("ether_type", 64'(want.ether_type), 64'(got.ether_type));
                check_field("source_mac", 64'(want.source_mac), 64'(got.source_mac));
                check_field("arp_operation", 64'(want.arp_operation),
                            64'(got.arp_operation));
                check_field("arp_sender_mac", 64'(want.arp_sender_mac),
                            64'(got.arp_sender_mac));
                check_field("source_addr", 64'(want.source_addr), 64'(got.source_addr));
                check_field("dest_addr", 64'(want.dest_addr), 64'(got.dest_addr));
                check_field("ip_protocol", 64'(want.ip_protocol), 64'(got.ip_protocol));
                check_field("source_port", 64'(want.source_port), 64'(got.source_port));
                check_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
                check_field("tcp_flag_bits", 64'(want.tcp_flag_bits),
                            64'(got.tcp_flag_bits));
                check_field("payload_start", 64'(want.payload_start),
                            64'(got.payload_start));
                check_field("payload_bytes", 64'(want.payload_bytes),
                            64'(got.payload_bytes));
            end
            records_checked++;
        end
    end

    function automatic logic [7:0] frame_byte_at(frame_cfg_t f, int p);
        logic [7:0] r;
        int         l4;
        case (f.fill)
            FILL_ZERO: r = 8'h00;
            FILL_ONES: r = 8'hFF;
            default:   r = 8'($urandom);
        endcase
        l4 = ETH_LEN + int'(f.ihl) * 4;
        if (p == 12) return f.etype[15:8];
        if (p == 13) return f.etype[7:0];
        if (f.etype == TYPE_IPV4) begin
            if (p == 14) return {r[7:4], f.ihl};
            if (p == 23) return f.proto;
            if (f.proto == IP_NUM_TCP && p == l4 + 12) return {f.doff, r[3:0]};
        end
        return r;
    endfunction

    function automatic int max_of(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Mostly well-formed frames with random content; some truncated, some noise.
    function automatic frame_cfg_t random_frame();
        frame_cfg_t f;
        int kind;
        int pick;
        int len;
        f = '0;
        kind = $urandom_range(0, 19);
        pick = $urandom_range(0, 9);
        f.ihl = (pick <= 5) ? 4'd5 : (pick <= 8) ? 4'($urandom_range(6, 15))
                                                 : 4'($urandom_range(0, 4));
        pick = $urandom_range(0, 9);
        f.doff = (pick <= 6) ? 4'd5 : (pick <= 8) ? 4'($urandom_range(6, 15))
                                                  : 4'($urandom_range(0, 4));
        pick = $urandom_range(0, 15);
        f.fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
        f.etype = TYPE_IPV4;
        if (kind <= 7) begin
            f.proto = IP_NUM_TCP;
            len = ETH_LEN + int'(f.ihl) * 4 + max_of(TCP_MIN, int'(f.doff) * 4)
                + $urandom_range(0, 24);
        end else if (kind <= 12) begin
            f.proto = IP_NUM_UDP;
            len = ETH_LEN + max_of(IP_MIN, int'(f.ihl) * 4 + UDP_LEN) + $urandom_range(0, 24);
        end else if (kind <= 15) begin
            f.etype = TYPE_ARP;
            len = ETH_LEN + ARP_LEN + $urandom_range(0, 18);
        end else if (kind == 16) begin
            f.proto = 8'($urandom_range(0, 255));
            if (f.proto == IP_NUM_TCP || f.proto == IP_NUM_UDP) f.proto = 8'd0;
            len = ETH_LEN + max_of(IP_MIN, int'(f.ihl) * 4) + $urandom_range(0, 16);
        end else if (kind == 17) begin
            f.etype = 16'($urandom);
            if (f.etype == TYPE_ARP || f.etype == TYPE_IPV4) f.etype[0] = 1'b1;
            len = $urandom_range(14, 64);
        end else begin
            f.etype = 16'($urandom);
            f.proto = 8'($urandom);
            f.ihl = 4'($urandom);
            len = $urandom_range(1, 80);
        end
        if (kind <= 16 && $urandom_range(0, 7) == 0) len = len - $urandom_range(1, 8);
        f.len = 17'(len);
        f.no_record = REC_PREDICTED;
        return f;
    endfunction

    // Offers one byte after a gap; returns at the edge where it was taken.
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_frame(input frame_cfg_t f);
        bit burst;
        int gap;
        frame_outcome_known.push_back(f.no_record);
        burst = hold_active || ($urandom_range(0, 3) == 0);
        for (int p = 0; p < int'(f.len); p++) begin
            if (burst) gap = 0;
            else if (f.len > 1000)
                gap = ($urandom_range(0, 511) == 0) ? $urandom_range(1, 14) : 0;
            else gap = $urandom_range(0, 14);
            send_byte(frame_byte_at(f, p), p == int'(f.len) - 1, gap);
        end
        frames_sent++;
        bytes_sent += int'(f.len);
    endtask

    // Receiver: random stalls, stretches without stalls, and one long hold-off.
    initial begin : receiver
        bit burst;
        int gap;
        burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_active = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_done = 1'b1;
            end else begin
                gap = burst ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 15) == 0) burst = !burst;
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d records outstanding",
                 cycle_count, pending_records.size());
        $display("FAILURE");
        $finish;
    end

    function automatic int bytes_sent_directed();
        int total;
        total = 0;
        for (int i = 0; i < DIRECTED_ROWS; i++) total += int'(directed_frames[i].len);
        return total;
    endfunction

    initial begin : stimulus
        int random_bytes;
        int random_frames;
        int record_base;
        directed_frames = '{
            // Short frames and a foreign EtherType.
            '{16'h1234,    17'd1,     4'd5,  IP_NUM_TCP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_ARP,    17'd13,    4'd5,  8'd0,       4'd5,  FILL_RANDOM, REC_NONE},
            '{16'h86DD,    17'd14,    4'd5,  8'd0,       4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_ARP,    17'd41,    4'd5,  8'd0,       4'd5,  FILL_RANDOM, REC_NONE},
            // ARP at minimum length, padded, and with extreme field values.
            '{TYPE_ARP,    17'd42,    4'd5,  8'd0,       4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_ARP,    17'd60,    4'd5,  8'd0,       4'd5,  FILL_ONES,   REC_PREDICTED},
            '{TYPE_ARP,    17'd42,    4'd5,  8'd0,       4'd5,  FILL_ZERO,   REC_PREDICTED},
            // IPv4 header lengths: short, other protocol, maximum IHL.
            '{TYPE_IPV4,   17'd33,    4'd5,  IP_NUM_TCP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_IPV4,   17'd34,    4'd5,  8'd1,       4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd73,    4'd15, IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_IPV4,   17'd82,    4'd15, IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            // TCP: short, empty payload, offset past the end, offset zero.
            '{TYPE_IPV4,   17'd53,    4'd5,  IP_NUM_TCP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_IPV4,   17'd54,    4'd5,  IP_NUM_TCP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd54,    4'd5,  IP_NUM_TCP, 4'd15, FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd60,    4'd5,  IP_NUM_TCP, 4'd0,  FILL_RANDOM, REC_PREDICTED},
            // UDP: short and empty payload.
            '{TYPE_IPV4,   17'd41,    4'd5,  IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_IPV4,   17'd42,    4'd5,  IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            // IHL below five puts the L4 header inside the IP header; then fill extremes.
            '{TYPE_IPV4,   17'd40,    4'd0,  IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd70,    4'd3,  IP_NUM_TCP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd94,    4'd5,  IP_NUM_TCP, 4'd15, FILL_ONES,   REC_PREDICTED},
            '{TYPE_IPV4,   17'd60,    4'd5,  IP_NUM_UDP, 4'd5,  FILL_ZERO,   REC_PREDICTED},
            // Largest frame accepted, then one byte more, then a normal frame.
            '{TYPE_IPV4,   17'd65535, 4'd5,  IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_PREDICTED},
            '{TYPE_IPV4,   17'd65536, 4'd5,  IP_NUM_UDP, 4'd5,  FILL_RANDOM, REC_NONE},
            '{TYPE_ARP,    17'd42,    4'd5,  8'd0,       4'd5,  FILL_RANDOM, REC_PREDICTED}
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) send_frame(directed_frames[i]);

        random_bytes = 0;
        random_frames = 0;
        record_base = records_predicted;
        while (random_bytes < RANDOM_BYTES || records_predicted < record_base + RANDOM_RECORDS)
        begin
            if (random_frames == 8) hold_request = 1'b1;
            send_frame(random_frame());
            random_bytes = bytes_sent - bytes_sent_directed();
            random_frames++;
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        // The edge waited for here lets the input monitor record the last frame first.
        @(posedge i_clk);
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frames (%0d bytes), %0d directed and the rest random.",
                 frames_sent, bytes_sent, DIRECTED_ROWS);
        $display("Checked %0d records; %0d frames gave no record; %0d mismatches.",
                 records_checked, frames_dropped, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/hep_pkg.sv
sv/hep_front.sv
sv/hep_fifo.sv
sv/hep_back.sv
sv/eth_arp_ipv4_l4_header_parser_top.sv
tb/sv/tb_top.sv
